// ===== sv/skri_pkg.sv =====
package skri_pkg;

   // Table geometry
   localparam int unsigned TABLE_DEPTH_DEF = 1024;
   localparam int unsigned POS_W_DEF       = $clog2(TABLE_DEPTH_DEF + 1);

   // Field widths
   localparam int unsigned KEY_W  = 32;
   localparam int unsigned ROW_W  = 32;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned KIND_W = 3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   // Query comparison kinds
   localparam logic [KIND_W-1:0] CMP_GT = 3'd0;
   localparam logic [KIND_W-1:0] CMP_GE = 3'd1;
   localparam logic [KIND_W-1:0] CMP_LT = 3'd2;
   localparam logic [KIND_W-1:0] CMP_LE = 3'd3;
   localparam logic [KIND_W-1:0] CMP_EQ = 3'd4;

   // Binary search step rule: move right when the probed entry is ...
   typedef enum logic [1:0] {
      SRCH_KEY_LT,   // key below the value
      SRCH_KEY_LE,   // key not above the value
      SRCH_PAIR_LE   // (key, row id) not above the given pair
   } srch_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SRCH_END,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic          load_req;
      logic          clear;
      logic          set_full;
      logic          srch_init;
      srch_mode_type srch_mode;
      logic          srch_cmp;
      logic          take_start;
      logic          take_end;
      logic          shift_init;
      logic          shift_step;
      logic          place;
      logic          finish;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [KIND_W-1:0] kind;
      logic              is_full;
      logic              srch_busy;
      logic              shift_done;
      logic              rsp_free;
   } sts_type;

endpackage

// ===== sv/skri_chan_if.sv =====
interface skri_req_if;
   logic                            valid;
   logic                            ready;
   logic [skri_pkg::OP_W-1:0]       operation;
   logic [skri_pkg::KEY_W-1:0]      key_value;
   logic [skri_pkg::ROW_W-1:0]      row_id;
   logic [skri_pkg::KIND_W-1:0]     compare_kind;

   modport source(output valid, operation, key_value, row_id, compare_kind, input ready);
   modport sink(input valid, operation, key_value, row_id, compare_kind, output ready);
endinterface

interface skri_rsp_if #(
   parameter int unsigned POS_W = skri_pkg::POS_W_DEF
);
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] range_start;
   logic [POS_W-1:0] range_end;
   logic             table_full;

   modport source(output valid, range_start, range_end, table_full, input ready);
   modport sink(input valid, range_start, range_end, table_full, output ready);
endinterface

// ===== sv/skri_ctrl.sv =====
module skri_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skri_pkg::sts_type sts,
   output skri_pkg::cmd_type cmd
);

   skri_pkg::state_type state_ff, state_in;
   logic                pass_ff, pass_in;

   // Hold state and search pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skri_pkg::ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      case (state_ff)
         skri_pkg::ST_IDLE: begin
            if (req_valid) state_in = skri_pkg::ST_DECODE;
         end
         skri_pkg::ST_DECODE: begin
            pass_in  = 1'b0;
            state_in = skri_pkg::ST_DONE;
            if (sts.op == skri_pkg::OP_INSERT && !sts.is_full) begin
               state_in = skri_pkg::ST_SRCH_RD;
            end
            if (sts.op == skri_pkg::OP_QUERY && sts.kind <= skri_pkg::CMP_EQ) begin
               state_in = skri_pkg::ST_SRCH_RD;
            end
         end
         skri_pkg::ST_SRCH_RD: begin
            state_in = sts.srch_busy ? skri_pkg::ST_SRCH_CMP : skri_pkg::ST_SRCH_END;
         end
         skri_pkg::ST_SRCH_CMP: begin
            state_in = skri_pkg::ST_SRCH_RD;
         end
         skri_pkg::ST_SRCH_END: begin
            if (sts.op == skri_pkg::OP_INSERT) begin
               state_in = skri_pkg::ST_SHIFT;
            end else if (sts.kind == skri_pkg::CMP_EQ && !pass_ff) begin
               pass_in  = 1'b1;
               state_in = skri_pkg::ST_SRCH_RD;
            end else begin
               state_in = skri_pkg::ST_DONE;
            end
         end
         skri_pkg::ST_SHIFT: begin
            if (sts.shift_done) state_in = skri_pkg::ST_PLACE;
         end
         skri_pkg::ST_PLACE: begin
            state_in = skri_pkg::ST_DONE;
         end
         skri_pkg::ST_DONE: begin
            if (sts.rsp_free) state_in = skri_pkg::ST_IDLE;
         end
         default: begin
            state_in = skri_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         skri_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         skri_pkg::ST_DECODE: begin
            case (sts.op)
               skri_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               skri_pkg::OP_INSERT: begin
                  if (sts.is_full) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.srch_init = 1'b1;
                     cmd.srch_mode = skri_pkg::SRCH_PAIR_LE;
                  end
               end
               skri_pkg::OP_QUERY: begin
                  case (sts.kind)
                     skri_pkg::CMP_GT, skri_pkg::CMP_LE: begin
                        cmd.srch_init = 1'b1;
                        cmd.srch_mode = skri_pkg::SRCH_KEY_LE;
                     end
                     skri_pkg::CMP_GE, skri_pkg::CMP_LT, skri_pkg::CMP_EQ: begin
                        cmd.srch_init = 1'b1;
                        cmd.srch_mode = skri_pkg::SRCH_KEY_LT;
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         skri_pkg::ST_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
         end
         skri_pkg::ST_SRCH_END: begin
            if (sts.op == skri_pkg::OP_INSERT) begin
               cmd.shift_init = 1'b1;
            end else begin
               case (sts.kind)
                  skri_pkg::CMP_GT, skri_pkg::CMP_GE: begin
                     cmd.take_start = 1'b1;
                  end
                  skri_pkg::CMP_LT, skri_pkg::CMP_LE: begin
                     cmd.take_end = 1'b1;
                  end
                  skri_pkg::CMP_EQ: begin
                     // lower bound first, then rerun for the upper bound
                     if (!pass_ff) begin
                        cmd.take_start = 1'b1;
                        cmd.srch_init  = 1'b1;
                        cmd.srch_mode  = skri_pkg::SRCH_KEY_LE;
                     end else begin
                        cmd.take_end = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         skri_pkg::ST_SHIFT: begin
            cmd.shift_step = 1'b1;
         end
         skri_pkg::ST_PLACE: begin
            cmd.place = 1'b1;
         end
         skri_pkg::ST_DONE: begin
            cmd.finish = sts.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/skri_dp.sv =====
module skri_dp #(
   parameter int unsigned TABLE_DEPTH = skri_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  skri_pkg::cmd_type             cmd,
   output skri_pkg::sts_type             sts,
   input  logic [skri_pkg::OP_W-1:0]     req_operation,
   input  logic [skri_pkg::KEY_W-1:0]    req_key_value,
   input  logic [skri_pkg::ROW_W-1:0]    req_row_id,
   input  logic [skri_pkg::KIND_W-1:0]   req_compare_kind,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [CNT_W-1:0]              rsp_range_start,
   output logic [CNT_W-1:0]              rsp_range_end,
   output logic                          rsp_table_full
);

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned DATA_W = skri_pkg::KEY_W + skri_pkg::ROW_W;

   // Entry store: key in the upper half, row id in the lower half
   logic [DATA_W-1:0] mem [TABLE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   logic [skri_pkg::OP_W-1:0]   op_ff, op_in;
   logic [skri_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [skri_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [skri_pkg::ROW_W-1:0]  row_ff, row_in;
   skri_pkg::srch_mode_type     mode_ff, mode_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            lo_ff, lo_in;
   logic [CNT_W-1:0]            hi_ff, hi_in;
   logic [CNT_W-1:0]            start_ff, start_in;
   logic [CNT_W-1:0]            end_ff, end_in;
   logic                        full_ff, full_in;
   logic [CNT_W-1:0]            ptr_ff, ptr_in;
   logic                        wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]           wr_addr_ff, wr_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]            rsp_start_ff, rsp_start_in;
   logic [CNT_W-1:0]            rsp_end_ff, rsp_end_in;
   logic                        rsp_full_ff, rsp_full_in;

   logic [CNT_W:0]              span_sum;
   logic [CNT_W-1:0]            mid;
   logic [CNT_W-1:0]            ptr_dec;
   logic                        shift_more;
   logic [skri_pkg::KEY_W-1:0]  mem_key;
   logic [skri_pkg::ROW_W-1:0]  mem_row;
   logic                        go_right;
   logic                        rsp_free;

   // Probe point and step decision
   assign span_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = span_sum[CNT_W:1];
   assign mem_key  = rd_data_ff[DATA_W-1:skri_pkg::ROW_W];
   assign mem_row  = rd_data_ff[skri_pkg::ROW_W-1:0];

   always_comb begin
      case (mode_ff)
         skri_pkg::SRCH_KEY_LT:  go_right = mem_key < key_ff;
         skri_pkg::SRCH_KEY_LE:  go_right = mem_key <= key_ff;
         skri_pkg::SRCH_PAIR_LE: go_right = (mem_key < key_ff) ||
                                            (mem_key == key_ff && mem_row <= row_ff);
         default:                go_right = 1'b0;
      endcase
   end

   // Shift walks down from the count to the insert point held in lo
   assign ptr_dec    = ptr_ff - 1'b1;
   assign shift_more = ptr_ff > lo_ff;

   assign rd_addr = cmd.shift_step ? ptr_dec[ADDR_W-1:0] : mid[ADDR_W-1:0];
   assign wr_en   = (cmd.shift_step && wr_pend_ff) || cmd.place;
   assign wr_addr = cmd.place ? lo_ff[ADDR_W-1:0] : wr_addr_ff;
   assign wr_data = cmd.place ? {key_ff, row_ff} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Next values
   always_comb begin
      op_in        = op_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      row_in       = row_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      full_in      = full_ff;
      ptr_in       = ptr_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_full_in  = rsp_full_ff;

      // capture the beat and preset the default result
      if (cmd.load_req) begin
         op_in    = req_operation;
         kind_in  = req_compare_kind;
         key_in   = req_key_value;
         row_in   = req_row_id;
         start_in = '0;
         end_in   = count_ff;
         full_in  = 1'b0;
      end
      if (cmd.clear) begin
         count_in = '0;
         end_in   = '0;
      end
      if (cmd.set_full) full_in = 1'b1;
      if (cmd.take_start) start_in = lo_ff;
      if (cmd.take_end) end_in = lo_ff;
      if (cmd.srch_init) begin
         lo_in   = '0;
         hi_in   = count_ff;
         mode_in = cmd.srch_mode;
      end
      if (cmd.srch_cmp) begin
         if (go_right) lo_in = mid + 1'b1;
         else hi_in = mid;
      end
      if (cmd.shift_init) begin
         ptr_in     = count_ff;
         wr_pend_in = 1'b0;
      end
      // move one entry up: read below the pointer, write it on the next shift step
      if (cmd.shift_step) begin
         wr_pend_in = shift_more;
         wr_addr_in = ptr_ff[ADDR_W-1:0];
         if (shift_more) ptr_in = ptr_dec;
      end
      if (cmd.place) begin
         count_in = count_ff + 1'b1;
         end_in   = count_ff + 1'b1;
      end
      // output register: load a finished result, drop a taken one
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = start_ff;
         rsp_end_in   = end_ff;
         rsp_full_in  = full_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      row_ff       <= row_in;
      mode_ff      <= mode_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      full_ff      <= full_in;
      ptr_ff       <= ptr_in;
      wr_addr_ff   <= wr_addr_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign sts.op         = op_ff;
   assign sts.kind       = kind_ff;
   assign sts.is_full    = count_ff == CNT_W'(TABLE_DEPTH);
   assign sts.srch_busy  = lo_ff < hi_ff;
   assign sts.shift_done = !shift_more && !wr_pend_ff;
   assign sts.rsp_free   = rsp_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_start = rsp_start_ff;
   assign rsp_range_end   = rsp_end_ff;
   assign rsp_table_full  = rsp_full_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_place_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance the entry count by one");

   a_probe_span: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_cmp |-> lo_ff < hi_ff)
      else $error("search step taken on an empty span");

   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_start_ff <= rsp_end_ff)
      else $error("result range start beyond range end");
`endif

endmodule

// ===== sv/sorted_key_range_index.sv =====
// A clear, an unknown operation or kind and a full-table insert go straight to the result.
// A query runs a binary search of at most ceil(log2(count+1)) steps, an equal query two; an
// insert runs one search, shifts the entries from the insert point up and places the entry.
// One item at a time: a new beat is taken once the last result is in the output register;
// a search step is a registered memory read plus a compare, a shift moves one entry.
// Reset clears entry count, controller and output valid; the entry memory is never cleared.
module sorted_key_range_index #(
   parameter int unsigned TABLE_DEPTH = skri_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   skri_req_if.sink    req_ch,
   skri_rsp_if.source  rsp_ch
);

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   skri_pkg::cmd_type cmd;
   skri_pkg::sts_type sts;
   logic              req_ready;

   skri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   skri_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_ch.operation),
      .req_key_value    (req_ch.key_value),
      .req_row_id       (req_ch.row_id),
      .req_compare_kind (req_ch.compare_kind),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_range_start  (rsp_ch.range_start),
      .rsp_range_end    (rsp_ch.range_end),
      .rsp_table_full   (rsp_ch.table_full)
   );

   assign req_ch.ready = req_ready;

endmodule

// ===== verif/sorted_key_range_index_tb.sv =====
`timescale 1ns / 100ps

typedef struct packed {
   logic [skri_pkg::OP_W-1:0]   operation;
   logic [skri_pkg::KEY_W-1:0]  key_value;
   logic [skri_pkg::ROW_W-1:0]  row_id;
   logic [skri_pkg::KIND_W-1:0] compare_kind;
} index_cmd_type;

typedef struct packed {
   logic [skri_pkg::POS_W_DEF-1:0] range_start;
   logic [skri_pkg::POS_W_DEF-1:0] range_end;
   logic                           table_full;
} index_rsp_type;

// Shadow of the sorted table; predicts one range beat per command
class range_index_scoreboard;
   localparam int unsigned KEY_W = skri_pkg::KEY_W;
   localparam int unsigned ROW_W = skri_pkg::ROW_W;
   localparam int unsigned POS_W = skri_pkg::POS_W_DEF;
   localparam int unsigned DEPTH = skri_pkg::TABLE_DEPTH_DEF;

   bit [KEY_W-1:0] shadow_keys [DEPTH];
   bit [ROW_W-1:0] shadow_rows [DEPTH];
   int unsigned    shadow_count;
   index_rsp_type  expected_ranges [$];
   int unsigned    fail_count;
   int unsigned    checked_count;
   int unsigned    full_drops;
   int unsigned    peak_count;
   int unsigned    op_seen [4];

   // First position whose key is above v (past_equal) or not below v
   function int unsigned key_bound(bit [KEY_W-1:0] v, bit past_equal);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (past_equal ? (shadow_keys[mid] <= v) : (shadow_keys[mid] < v))
            lo = mid + 1;
         else
            hi = mid;
      end
      return lo;
   endfunction

   // First position whose (key, row) pair is above (k, r)
   function int unsigned pair_bound(bit [KEY_W-1:0] k, bit [ROW_W-1:0] r);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_keys[mid] < k || (shadow_keys[mid] == k && shadow_rows[mid] <= r))
            lo = mid + 1;
         else
            hi = mid;
      end
      return lo;
   endfunction

   function void note_command(index_cmd_type c);
      index_rsp_type r;
      int unsigned   pos, i;
      r = '0;
      op_seen[c.operation]++;
      case (c.operation)
         skri_pkg::OP_CLEAR: begin
            shadow_count = 0;
         end
         skri_pkg::OP_INSERT: begin
            if (shadow_count >= DEPTH) begin
               r.table_full = 1'b1;
               full_drops++;
            end else begin
               // shift the tail up and drop the entry in after any identical pair
               pos = pair_bound(c.key_value, c.row_id);
               for (i = shadow_count; i > pos; i--) begin
                  shadow_keys[i] = shadow_keys[i - 1];
                  shadow_rows[i] = shadow_rows[i - 1];
               end
               shadow_keys[pos] = c.key_value;
               shadow_rows[pos] = c.row_id;
               shadow_count++;
            end
         end
         default: ;
      endcase
      r.range_end = POS_W'(shadow_count);
      if (c.operation == skri_pkg::OP_QUERY) begin
         case (c.compare_kind)
            skri_pkg::CMP_GT: r.range_start = POS_W'(key_bound(c.key_value, 1'b1));
            skri_pkg::CMP_GE: r.range_start = POS_W'(key_bound(c.key_value, 1'b0));
            skri_pkg::CMP_LT: r.range_end   = POS_W'(key_bound(c.key_value, 1'b0));
            skri_pkg::CMP_LE: r.range_end   = POS_W'(key_bound(c.key_value, 1'b1));
            skri_pkg::CMP_EQ: begin
               r.range_start = POS_W'(key_bound(c.key_value, 1'b0));
               r.range_end   = POS_W'(key_bound(c.key_value, 1'b1));
            end
            // unknown kinds match the whole table
            default: ;
         endcase
      end
      if (shadow_count > peak_count)
         peak_count = shadow_count;
      expected_ranges.push_back(r);
   endfunction

   function void check_range(index_rsp_type got);
      index_rsp_type want;
      if (expected_ranges.size() == 0) begin
         $error("result beat with nothing expected: range_start %0d range_end %0d %s %0d",
                got.range_start, got.range_end, "table_full", got.table_full);
         fail_count++;
         return;
      end
      want = expected_ranges.pop_front();
      checked_count++;
      if (got.range_start !== want.range_start) begin
         $error("range_start: expected %0d, got %0d", want.range_start, got.range_start);
         fail_count++;
      end
      if (got.range_end !== want.range_end) begin
         $error("range_end: expected %0d, got %0d", want.range_end, got.range_end);
         fail_count++;
      end
      if (got.table_full !== want.table_full) begin
         $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
         fail_count++;
      end
   endfunction
endclass

module sorted_key_range_index_tb;

   localparam int unsigned OP_W   = skri_pkg::OP_W;
   localparam int unsigned KEY_W  = skri_pkg::KEY_W;
   localparam int unsigned ROW_W  = skri_pkg::ROW_W;
   localparam int unsigned KIND_W = skri_pkg::KIND_W;
   localparam int unsigned DEPTH  = skri_pkg::TABLE_DEPTH_DEF;

   // Opcode and compare kinds the block does not define
   localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0] CMP_LAST  = '1;

   localparam int unsigned RANDOM_ITEMS = 650;
   localparam int unsigned CALM_ITEMS   = 120;
   localparam int unsigned DRAIN_LIMIT  = 20000;
   localparam int unsigned TAIL_CYCLES  = 50;

   logic clock;
   logic reset;

   skri_req_if req_ch ();
   skri_rsp_if rsp_ch ();

   sorted_key_range_index dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   range_index_scoreboard scoreboard = new();

   int unsigned      send_gap_pct;
   int unsigned      stall_pct;
   int unsigned      work_count;
   logic [KEY_W-1:0] key_pool [8];

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Send one command beat, with an optional idle burst ahead of it
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [ROW_W-1:0] row, input logic [KIND_W-1:0] kind);
      index_cmd_type c;
      c.operation    = op;
      c.key_value    = key;
      c.row_id       = row;
      c.compare_kind = kind;
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.key_value    <= key;
      req_ch.row_id       <= row;
      req_ch.compare_kind <= kind;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      scoreboard.note_command(c);
      if (op != OP_UNUSED)
         work_count++;
   endtask

   function automatic void pick_idling();
      case ($urandom_range(0, 3))
         0: begin send_gap_pct = 0;  stall_pct = 0;  end
         1: begin send_gap_pct = 10; stall_pct = 3;  end
         2: begin send_gap_pct = 30; stall_pct = 8;  end
         default: begin send_gap_pct = 5; stall_pct = 15; end
      endcase
   endfunction

   // Small pool of keys per session so duplicates and equal hits are common
   function automatic void refill_key_pool();
      foreach (key_pool[i]) begin
         case ($urandom_range(0, 3))
            0: key_pool[i] = $urandom_range(0, 15);
            1: key_pool[i] = '1 - $urandom_range(0, 3);
            default: key_pool[i] = $urandom;
         endcase
      end
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         7: return key_pool[$urandom_range(0, 7)] + 1;
         8: return key_pool[$urandom_range(0, 7)] - 1;
         9: return $urandom;
         default: return key_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic logic [ROW_W-1:0] pick_row();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] any_kind();
      return KIND_W'($urandom_range(0, CMP_LAST));
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      if ($urandom_range(0, 9) != 0)
         return KIND_W'($urandom_range(skri_pkg::CMP_GT, skri_pkg::CMP_EQ));
      return KIND_W'($urandom_range(skri_pkg::CMP_EQ + 1, CMP_LAST));
   endfunction

   // Build a table from a fresh pool and query it, mostly after a clear
   task automatic run_session(input bit calm);
      int unsigned n, i;
      refill_key_pool();
      if (!calm)
         pick_idling();
      if (scoreboard.shadow_count > 150 || $urandom_range(0, 4) != 0)
         send_cmd(skri_pkg::OP_CLEAR, $urandom, $urandom, any_kind());
      n = $urandom_range(1, 64);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 6)
            send_cmd(skri_pkg::OP_INSERT, pick_key(), pick_row(), any_kind());
         else
            send_cmd(skri_pkg::OP_QUERY, pick_key(), $urandom, pick_kind());
      end
   endtask

   // Accept result beats and stall the result channel in random bursts
   initial begin : result_sink
      int unsigned   stall_left;
      index_rsp_type got;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.range_start = rsp_ch.range_start;
            got.range_end   = rsp_ch.range_end;
            got.table_full  = rsp_ch.table_full;
            scoreboard.check_range(got);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int unsigned     target, i, n, k, drain_cycles;
      logic [OP_W-1:0] op;
      send_gap_pct = 0;
      stall_pct    = 0;
      work_count   = 0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= skri_pkg::OP_CLEAR;
      req_ch.key_value    <= '0;
      req_ch.row_id       <= '0;
      req_ch.compare_kind <= skri_pkg::CMP_GT;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extreme keys and rows, ties, every kind
      send_cmd(skri_pkg::OP_QUERY,  '0, '0, skri_pkg::CMP_GT);
      send_cmd(OP_UNUSED, '1, '1, CMP_LAST);
      send_cmd(skri_pkg::OP_INSERT, '1, '1, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_INSERT, '0, '0, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_INSERT, '0, '1, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_INSERT, '0, '0, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_INSERT, 32'h8000_0000, 32'h1234_5678, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_INSERT, 32'h8000_0000, '0, skri_pkg::CMP_GT);
      for (k = skri_pkg::CMP_GT; k <= skri_pkg::CMP_EQ; k++)
         send_cmd(skri_pkg::OP_QUERY, 32'h8000_0000, '1, KIND_W'(k));
      send_cmd(skri_pkg::OP_QUERY,  '0, '0, skri_pkg::CMP_EQ);
      send_cmd(skri_pkg::OP_QUERY,  '1, '0, skri_pkg::CMP_EQ);
      send_cmd(skri_pkg::OP_QUERY,  '1, '0, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_QUERY,  '0, '0, skri_pkg::CMP_LT);
      send_cmd(skri_pkg::OP_QUERY,  32'h7FFF_FFFF, '0, KIND_W'(skri_pkg::CMP_EQ + 1));
      send_cmd(skri_pkg::OP_QUERY,  32'h5555_5555, '0, CMP_LAST);
      send_cmd(OP_UNUSED, '0, '0, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_CLEAR,  '1, '1, CMP_LAST);
      send_cmd(skri_pkg::OP_QUERY,  '1, '0, skri_pkg::CMP_LE);
      send_cmd(skri_pkg::OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, skri_pkg::CMP_GT);

      // random: well-formed sessions mixed with noise and stray clears
      target = work_count + RANDOM_ITEMS;
      while (work_count < target) begin
         if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
               op = ($urandom_range(0, 1) == 0) ? OP_UNUSED
                  : OP_W'($urandom_range(skri_pkg::OP_CLEAR, skri_pkg::OP_QUERY));
               send_cmd(op, $urandom, $urandom, any_kind());
            end
         end else begin
            run_session(1'b0);
         end
      end

      // fill the table in key order so the shifts stay short, then overflow it
      pick_idling();
      send_cmd(skri_pkg::OP_CLEAR, '0, '0, skri_pkg::CMP_GT);
      for (i = 0; i < DEPTH; i++) begin
         if (i == 0)
            send_cmd(skri_pkg::OP_INSERT, '0, $urandom, skri_pkg::CMP_GT);
         else if (i == DEPTH - 1)
            send_cmd(skri_pkg::OP_INSERT, '1, $urandom, skri_pkg::CMP_GT);
         else
            send_cmd(skri_pkg::OP_INSERT, {i[9:0], 22'($urandom)}, $urandom,
                     skri_pkg::CMP_GT);
      end
      send_cmd(skri_pkg::OP_INSERT, '0, '0, skri_pkg::CMP_GT);
      send_cmd(skri_pkg::OP_INSERT, '1, '1, skri_pkg::CMP_EQ);
      send_cmd(skri_pkg::OP_INSERT, $urandom, $urandom, skri_pkg::CMP_GT);
      for (k = 0; k <= CMP_LAST; k++) begin
         send_cmd(skri_pkg::OP_QUERY, '0, '0, KIND_W'(k));
         send_cmd(skri_pkg::OP_QUERY, '1, '0, KIND_W'(k));
         send_cmd(skri_pkg::OP_QUERY, $urandom, '0, KIND_W'(k));
      end
      send_cmd(OP_UNUSED, $urandom, $urandom, skri_pkg::CMP_GT);

      // final stretch with both sides at full rate
      send_gap_pct = 0;
      stall_pct    = 0;
      target = work_count + CALM_ITEMS;
      while (work_count < target)
         run_session(1'b1);
      req_ch.valid <= 1'b0;

      // drain, then hold a little longer for stray beats
      drain_cycles = 0;
      while (scoreboard.expected_ranges.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.expected_ranges.size() != 0) begin
         $error("%0d expected result beats never arrived", scoreboard.expected_ranges.size());
         scoreboard.fail_count++;
      end

      $display("Ran %0d clears, %0d inserts (%0d refused on a full table), %0d queries,",
               scoreboard.op_seen[skri_pkg::OP_CLEAR], scoreboard.op_seen[skri_pkg::OP_INSERT],
               scoreboard.full_drops, scoreboard.op_seen[skri_pkg::OP_QUERY]);
      $display("%0d unused opcodes; compared %0d result beats; table peaked at %0d entries",
               scoreboard.op_seen[OP_UNUSED], scoreboard.checked_count,
               scoreboard.peak_count);
      if (scoreboard.fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // bound well above the slowest legal run: every beat a full-length shift plus both stalls
   initial begin : watchdog
      #250_000_000;
      $error("timeout waiting for the run to complete");
      $display("simulation failed");
      $finish;
   end

endmodule
